FILE: rtl/core/bsws_pkg.sv
// ----------------------------------------------------------------------------
// Bounded stack with search: shared definitions
// Command and status codes, stack depth and the transaction payload types.
// ----------------------------------------------------------------------------
package bsws_pkg;

  localparam int DEPTH  = 8;
  localparam int WORD_W = 32;
  localparam int CNT_W  = 4;
  localparam int DIST_W = 3;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_SEARCH = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [WORD_W-1:0] operand;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [WORD_W-1:0] top_word;
    logic [DIST_W-1:0]        distance;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;
    logic                     is_full;
  } out_t;

  // Shift control shared by every cell of the row.
  typedef struct packed {
    logic push;
    logic pop;
  } shift_t;

endpackage

FILE: rtl/core/bsws_cell.sv
// ----------------------------------------------------------------------------
// Bounded stack with search: storage cell
// Holds one stack word, shifts with its neighbors, compares against the key.
// ----------------------------------------------------------------------------
module bsws_cell import bsws_pkg::*; (
  input  logic                     clk_i,
  input  shift_t                   shift_i,
  input  logic signed [WORD_W-1:0] above_i,
  input  logic signed [WORD_W-1:0] below_i,
  input  logic signed [WORD_W-1:0] key_i,
  input  logic                     live_i,
  output logic signed [WORD_W-1:0] word_o,
  output logic                     hit_o
);

  logic signed [WORD_W-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    if (shift_i.push) begin
      word_d = above_i;
    end else if (shift_i.pop) begin
      word_d = below_i;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  // Match only counts for a cell that holds a live entry.
  assign hit_o  = live_i && (word_q == key_i);

endmodule

FILE: rtl/core/bounded_stack_with_search.sv
// ----------------------------------------------------------------------------
// Bounded stack with search: top level
// LIFO of signed 32-bit words built as a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one command
//   and operand per transaction: push, pop, peek, clear or search. Unused
//   command codes act as no-ops with status ok.
//   Output channel (out_valid_o / out_ready_i / out_data_o) returns exactly
//   one result per command: status, peeked word, search distance, and the
//   fill count with empty and full flags after the command.
//   The result is registered and presented in the cycle after the command is taken.
//   Throughput: one command per cycle while results are taken. Cell 0 is
//   the top of the stack; a push or pop shifts the whole row by one cell,
//   and a search compares every cell at once, so nothing iterates.
//   Reset clears the fill count and the output valid flag; the cell words
//   and the result payload are not reset and are never observed until
//   written.
//   When the receiver stalls, the result stays in the output register and
//   in_ready_o drops, so at most one result is ever held.
// ----------------------------------------------------------------------------
module bounded_stack_with_search import bsws_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic [CNT_W-1:0]         count_q, count_d;
  logic                     out_valid_q, out_valid_d;
  out_t                     out_q, out_d;
  logic                     accept;
  logic                     full, empty;
  shift_t                   shift;
  logic signed [WORD_W-1:0] cell_word [DEPTH];
  logic [DEPTH-1:0]         hit;
  logic                     hit_any;
  logic [DIST_W-1:0]        hit_dist;

  // Take a new command whenever the output register is free or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  // Row of cells: cell 0 is the top, pushes move words toward the bottom.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] above, below;
    if (i == 0) begin : g_top
      assign above = in_data_i.operand;
    end else begin : g_mid_above
      assign above = cell_word[i-1];
    end
    if (i == DEPTH-1) begin : g_bottom
      assign below = cell_word[i];
    end else begin : g_mid_below
      assign below = cell_word[i+1];
    end

    bsws_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .above_i (above),
      .below_i (below),
      .key_i   (in_data_i.operand),
      .live_i  (CNT_W'(i) < count_q),
      .word_o  (cell_word[i]),
      .hit_o   (hit[i])
    );
  end

  // Nearest match to the top wins: the lowest cell index that hits.
  always_comb begin
    hit_dist = '0;
    for (int i = DEPTH-1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_dist = DIST_W'(i);
      end
    end
  end
  assign hit_any = |hit;

  // Command decode: shift control, next count and the result word.
  always_comb begin
    shift          = '0;
    count_d        = count_q;
    out_d          = '0;
    out_d.status   = ST_OK;
    unique case (cmd_e'(in_data_i.command))
      CMD_PUSH: begin
        if (full) begin
          out_d.status = ST_OVERFLOW;
        end else begin
          shift.push = accept;
          count_d    = count_q + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (empty) begin
          out_d.status = ST_EMPTY;
        end else begin
          shift.pop = accept;
          count_d   = count_q - CNT_W'(1);
        end
      end
      CMD_PEEK: begin
        if (empty) begin
          out_d.status = ST_EMPTY;
        end else begin
          out_d.top_word = cell_word[0];
        end
      end
      CMD_CLEAR: begin
        count_d = '0;
      end
      CMD_SEARCH: begin
        if (hit_any) begin
          out_d.distance = hit_dist;
        end else begin
          out_d.status = ST_NOT_FOUND;
        end
      end
      default: begin
        // Unused codes: no-op, status ok.
      end
    endcase
    out_d.count    = count_d;
    out_d.is_empty = (count_d == '0);
    out_d.is_full  = (count_d == CNT_W'(DEPTH));
  end

  // Hold a stalled result; drop it once taken with nothing new behind it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_data_i.command == CMD_PUSH) && !full
    |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("push did not grow the stack");

  a_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.is_empty == (out_data_o.count == '0)) &&
                    (out_data_o.is_full == (out_data_o.count == CNT_W'(DEPTH))))
    else $error("empty/full flags disagree with count");

  a_miss_no_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_NOT_FOUND) |-> out_data_o.distance == '0)
    else $error("search miss with nonzero distance");
`endif

endmodule
